>>> hw/rtl/scc_pkg.sv
// shared types, constants and the crc-8 byte update for the scratchpad check
// no dependencies
package scc_pkg;

  localparam int unsigned ScratchpadBytesDef = 9;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned TempW = 17;

  // reflected form of the 1-wire polynomial x^8 + x^5 + x^4 + 1
  localparam logic [7:0] CrcPolyRefl = 8'h8C;

  // upper nibble of the high byte marks a negative reading
  localparam logic [7:0] SignNibbleMask = 8'hF0;

  // one byte into the running crc, eight shift steps
  // (same values as the 256-entry table: 0, 94, 188, 226, ...)
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // one registered byte on its way into the accumulator
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } step_t;

  // what the accumulator reports for the byte in front of it
  typedef struct packed {
    logic                    last;
    logic signed [TempW-1:0] temp;
    logic                    crc_error;
  } result_t;

endpackage

>>> hw/rtl/scc_accum.sv
// running crc, byte count and temperature bytes of one scratchpad
// depends on scc_pkg
module scc_accum #(
  parameter int unsigned SCRATCHPAD_BYTES = scc_pkg::ScratchpadBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scc_pkg::step_t   step_i,
  input  logic             take_i,
  output scc_pkg::result_t result_o
);
  import scc_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SCRATCHPAD_BYTES - 1);

  logic [7:0]      crc_q, crc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      low_q, low_d;
  logic [7:0]      high_q, high_d;
  logic [7:0]      crc_next;
  logic            last;

  assign crc_next = crc8_byte(crc_q, step_i.data);
  // a count at or past the end still closes the scratchpad
  assign last     = (idx_q >= LastIdx);

  always_comb begin
    result_o.last      = last;
    result_o.crc_error = (crc_next != 8'h00);
    if (crc_next != 8'h00) begin
      result_o.temp = '0;
    end else if ((high_q & SignNibbleMask) != 8'h00) begin
      result_o.temp = {1'b1, high_q, low_q};
    end else begin
      result_o.temp = {1'b0, high_q, low_q};
    end
  end

  always_comb begin
    crc_d  = crc_q;
    idx_d  = idx_q;
    low_d  = low_q;
    high_d = high_q;
    if (take_i && step_i.valid) begin
      if (last) begin
        crc_d  = '0;
        idx_d  = '0;
        low_d  = '0;
        high_d = '0;
      end else begin
        crc_d = crc_next;
        idx_d = idx_q + 1'b1;
        if (idx_q == '0) begin
          low_d = step_i.data;
        end
        if (idx_q == IdxW'(1)) begin
          high_d = step_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      idx_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else begin
      crc_q  <= crc_d;
      idx_q  <= idx_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

endmodule

>>> hw/rtl/scratchpad_crc_temperature_check_unit.sv
// a byte is registered on entry and enters the crc once it is taken from that register;
// the result of a scratchpad is registered when its closing byte is taken from there
// throughput: one byte per cycle, set by the single-byte crc update; a held
// result stalls only the closing byte of the next scratchpad
// reset: asynchronous, active low; clears crc, byte count, stored bytes and valids
// top level, depends on scc_pkg and scc_accum
module scratchpad_crc_temperature_check_unit #(
  parameter int unsigned SCRATCHPAD_BYTES = scc_pkg::ScratchpadBytesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [scc_pkg::TempW-1:0] temp_sixteenths_o,
  output logic                             crc_error_o
);
  import scc_pkg::*;

  step_t                   step_q, step_d;
  result_t                 res;
  logic                    out_valid_q, out_valid_d;
  logic signed [TempW-1:0] temp_q, temp_d;
  logic                    err_q, err_d;
  logic                    out_free;
  logic                    take;
  logic                    in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  // only the closing byte needs room in the result register
  assign take       = step_q.valid && (!res.last || out_free);
  assign in_stall_o = step_q.valid && !take;
  assign in_xfer    = in_valid_i && !in_stall_o;

  scc_accum #(
    .SCRATCHPAD_BYTES(SCRATCHPAD_BYTES)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_q),
    .take_i  (take),
    .result_o(res)
  );

  always_comb begin
    step_d = step_q;
    if (in_xfer) begin
      step_d.valid = 1'b1;
      step_d.data  = data_byte_i;
    end else if (take) begin
      step_d.valid = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    temp_d      = temp_q;
    err_d       = err_q;
    if (take && res.last) begin
      out_valid_d = 1'b1;
      temp_d      = res.temp;
      err_d       = res.crc_error;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    err_q  <= err_d;
  end

  assign out_valid_o       = out_valid_q;
  assign temp_sixteenths_o = temp_q;
  assign crc_error_o       = err_q;

endmodule

>>> hw/rtl/scc_checker.sv
// port-level checks for the scratchpad check unit, bound to the top level
// depends on scc_pkg and scratchpad_crc_temperature_check_unit
module scc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [7:0]                       data_byte_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [scc_pkg::TempW-1:0] temp_sixteenths_o,
  input logic                             crc_error_o
);

  // a stalled result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temp_sixteenths_o)
      && $stable(crc_error_o))
    else $error("result changed while stalled");

  // stalled input payload holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i))
    else $error("input changed while stalled");

  // failed crc forces a zero reading
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_error_o |-> temp_sixteenths_o == '0)
    else $error("nonzero temperature with crc error");

  // positive readings never exceed twelve magnitude bits
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !crc_error_o && !temp_sixteenths_o[16] |->
      temp_sixteenths_o[15:12] == 4'h0)
    else $error("positive temperature out of range");

endmodule

bind scratchpad_crc_temperature_check_unit scc_checker u_scc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .data_byte_i      (data_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .temp_sixteenths_o(temp_sixteenths_o),
  .crc_error_o      (crc_error_o)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the 1-wire scratchpad crc and temperature unit
// depends on scc_pkg and scratchpad_crc_temperature_check_unit; holds its own scoreboard class
module testbench;

  localparam int unsigned PadBytes  = scc_pkg::ScratchpadBytesDef;
  localparam int unsigned TempW     = scc_pkg::TempW;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ReportMax = 10;

  typedef struct {
    logic signed [TempW-1:0] temp;
    logic                    crc_error;
  } reading_t;

  typedef enum int unsigned {PadGood, PadFlip, PadNoise} pad_kind_e;
  typedef enum int unsigned {StallNone, StallCoin, StallHold} stall_mode_e;

  // running crc and temperature bytes of the scratchpad being received
  class scratchpad_board;
    reading_t   readings_q[$];
    bit [7:0]   crc_acc;
    bit [3:0]   byte_cnt;
    bit [7:0]   lo_byte;
    bit [7:0]   hi_byte;
    int unsigned bad_cnt;
    int unsigned result_cnt;

    function new();
      crc_acc    = '0;
      byte_cnt   = '0;
      lo_byte    = '0;
      hi_byte    = '0;
      bad_cnt    = 0;
      result_cnt = 0;
    endfunction

    // bit-serial 1-wire crc, lsb of the data first
    static function bit [7:0] crc_mix(bit [7:0] crc, bit [7:0] d);
      bit fb;
      for (int i = 0; i < 8; i++) begin
        fb  = crc[0] ^ d[i];
        crc = crc >> 1;
        if (fb) crc = crc ^ scc_pkg::CrcPolyRefl;
      end
      return crc;
    endfunction

    function void note_byte(bit [7:0] b);
      reading_t r;
      crc_acc = crc_mix(crc_acc, b);
      if (byte_cnt == 0) lo_byte = b;
      else if (byte_cnt == 1) hi_byte = b;
      if (32'(byte_cnt) + 1 < PadBytes) begin
        byte_cnt = byte_cnt + 1;
        return;
      end
      r.crc_error = (crc_acc != 0);
      if (r.crc_error) r.temp = '0;
      else r.temp = {(|hi_byte[7:4]), hi_byte, lo_byte};
      readings_q.push_back(r);
      crc_acc  = '0;
      byte_cnt = '0;
      lo_byte  = '0;
      hi_byte  = '0;
    endfunction

    function void check_result(logic signed [TempW-1:0] temp, logic crc_error);
      reading_t r;
      result_cnt++;
      if (readings_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= ReportMax)
          $display("result %0d: none expected, got temp %0d crc_error %b",
                   result_cnt, temp, crc_error);
        return;
      end
      r = readings_q.pop_front();
      if (temp !== r.temp || crc_error !== r.crc_error) begin
        bad_cnt++;
        if (bad_cnt <= ReportMax)
          $display("result %0d: expected temp %0d crc_error %b, got temp %0d crc_error %b",
                   result_cnt, r.temp, r.crc_error, temp, crc_error);
      end
    endfunction

    function int pending();
      return readings_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              data_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [TempW-1:0] temp_sixteenths;
  logic                    crc_error;

  scratchpad_board sb = new();

  int unsigned burst_left = 0;
  int unsigned quiet_cnt  = 0;

  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  scratchpad_crc_temperature_check_unit #(
    .SCRATCHPAD_BYTES(PadBytes)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .temp_sixteenths_o(temp_sixteenths),
    .crc_error_o      (crc_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfers on both channels, plus the quiet-cycle watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(data_byte);
      if (out_valid && !out_stall) sb.check_result(temp_sixteenths, crc_error);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt + 1 >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // receiver back-pressure, switching between free running, coin toss and long holds
  always @(negedge clk) begin
    if (rst_n) begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 80);
      end
      mode_left--;
      case (stall_mode)
        StallNone: begin
          out_stall <= 1'b0;
        end
        StallCoin: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
          end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // one byte, with the sender idling between bursts
  task automatic send_byte(input bit [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic send_pad(input bit [7:0] lo, input bit [7:0] hi, input pad_kind_e kind);
    bit [7:0] pad [PadBytes];
    bit [7:0] crc;
    crc = '0;
    for (int i = 0; i < PadBytes; i++) pad[i] = 8'($urandom);
    if (kind != PadNoise) begin
      pad[0] = lo;
      pad[1] = hi;
      for (int i = 0; i < PadBytes - 1; i++) crc = scratchpad_board::crc_mix(crc, pad[i]);
      // closing byte makes the crc over the whole pad zero
      pad[PadBytes-1] = crc;
    end
    if (kind == PadFlip) begin
      crc = 8'(1 << $urandom_range(0, 7));
      pad[$urandom_range(0, PadBytes - 1)] ^= crc;
    end
    for (int i = 0; i < PadBytes; i++) send_byte(pad[i]);
  endtask

  // sender holds off until every outstanding reading has come back
  task automatic drain_readings();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic bit [7:0] pick_lo();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [7:0] pick_hi();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h0F;
      2:       return 8'h10;
      3:       return 8'hF0;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sel;
    pad_kind_e   kind;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    data_byte = '0;
    out_stall = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // largest positive reading, all-ones raw value, and a corrupted pad
    send_pad(8'hFF, 8'h0F, PadGood);
    send_pad(8'hFF, 8'hFF, PadGood);
    send_pad(8'h00, 8'h80, PadFlip);
    drain_readings();

    for (int n = 0; n < 80; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) kind = PadGood;
      else if (sel < 17) kind = PadFlip;
      else kind = PadNoise;
      send_pad(pick_lo(), pick_hi(), kind);
      if (n == 40) drain_readings();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.bad_cnt == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_accum.sv
hw/rtl/scratchpad_crc_temperature_check_unit.sv
hw/rtl/scc_checker.sv
tb/testbench.sv
